@@ rtl/core/lpr_pkg.sv @@
// Shared types and codes for the longest-prefix route lookup block.
package lpr_pkg;

  localparam int LPR_ROUTE_ENTRIES = 32;
  localparam int LPR_INTERFACES    = 16;
  localparam int LPR_MAX_LEN       = 32;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_ROUTE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_ADDED    = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_FORWARD  = 3'd2,
    STAT_EXPIRED  = 3'd3,
    STAT_NO_ROUTE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [31:0] prefix;
    logic [5:0]  length;
    logic        has_gateway;
    logic [31:0] gateway;
    logic [3:0]  iface;
  } entry_t;

endpackage

@@ rtl/core/lpr_table.sv @@
// Route table memory: one write port, one registered read port.
module lpr_table
  import lpr_pkg::*;
#(
  parameter int ENTRIES = LPR_ROUTE_ENTRIES,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output entry_t        rd_data,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  entry_t        wr_data
);

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/ipv4_longest_prefix_router.sv @@
// Top level: IPv4 route table with add and longest-prefix forwarding commands.
//
// Usage: drive the in_ ports and raise start while busy is low; the beat is
// taken on that edge and busy rises until the result has been issued.
// in_command selects adding a route or routing a datagram.
// Every command gives exactly one result beat on the out_ ports, marked by
// out_valid for one cycle. The receiver cannot stall; it must take each beat.
// Timing: the table is read one entry per cycle from its memory port, over
// the routes stored so far; a datagram whose TTL is zero or one skips the
// scan and goes straight to its result. A new command may be started in the
// cycle that its predecessor's result is shown.
// Routes fill the lowest free slot and are never removed, so the set of valid
// entries is tracked by a fill count rather than per-entry valid bits.
// Reset (rst_n low, synchronous) empties the table at once and clears busy
// and out_valid; no clearing pass is needed.
module ipv4_longest_prefix_router
  import lpr_pkg::*;
#(
  parameter int ROUTE_ENTRIES = LPR_ROUTE_ENTRIES,
  parameter int INTERFACES    = LPR_INTERFACES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [31:0] in_address,
  input  logic [5:0]  in_prefix_length,
  input  logic        in_has_next_hop,
  input  logic [31:0] in_next_hop,
  input  logic [3:0]  in_interface_index,
  input  logic [7:0]  in_ttl,
  input  logic [7:0]  in_protocol,
  input  logic [15:0] in_header_checksum,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [3:0]  out_interface,
  output logic [31:0] out_fwd_address,
  output logic [7:0]  out_new_ttl,
  output logic [15:0] out_new_checksum
);

  localparam int IW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int CW = $clog2(ROUTE_ENTRIES + 1);

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) begin
      m = 32'd0;
    end else if (len >= 6'(LPR_MAX_LEN)) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = 32'hFFFF_FFFF << (6'(LPR_MAX_LEN) - len);
    end
    return m;
  endfunction

  // Ones' complement update of the checksum for the changed TTL/protocol word.
  function automatic logic [15:0] csum_update(input logic [15:0] csum,
                                              input logic [7:0]  ttl,
                                              input logic [7:0]  proto);
    logic [15:0] old_word;
    logic [15:0] new_word;
    logic [17:0] sum;
    logic [16:0] f1;
    logic [16:0] f2;
    old_word = {ttl, proto};
    new_word = {ttl - 8'd1, proto};
    sum = {2'b00, ~csum} + {2'b00, ~old_word} + {2'b00, new_word};
    f1  = {1'b0, sum[15:0]} + {15'd0, sum[17:16]};
    f2  = {1'b0, f1[15:0]} + {16'd0, f1[16]};
    return ~f2[15:0];
  endfunction

  state_t state_r, state_nxt;

  // latched command
  logic        cmd_r;
  logic [31:0] addr_r;
  logic [5:0]  plen_r;
  logic        hasgw_r;
  logic [31:0] gw_r;
  logic [3:0]  ifc_r;
  logic [7:0]  ttl_r;
  logic [7:0]  proto_r;
  logic [15:0] csum_r;

  logic [CW-1:0] count_r;
  logic [CW-1:0] rd_idx_r;
  logic          rd_pend_r;
  logic [IW-1:0] cmp_idx_r;

  logic          hit_r;
  logic [IW-1:0] hit_idx_r;
  logic          best_v_r;
  logic [5:0]    best_len_r;
  logic [3:0]    best_ifc_r;
  logic          best_hasgw_r;
  logic [31:0]   best_gw_r;

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [3:0]  out_ifc_r;
  logic [31:0] out_addr_r;
  logic [7:0]  out_ttl_r;
  logic [15:0] out_csum_r;

  entry_t        rd_data;
  entry_t        wr_data;
  logic          rd_en;
  logic          wr_en;
  logic [IW-1:0] wr_addr;

  logic    accept;
  logic    expire_in;
  logic    issue;
  logic    finish;
  logic    ttl_dead;
  logic    add_match;
  logic    route_match;
  logic    route_better;
  logic    has_room;
  logic    ifc_ok;
  status_t fin_status;
  logic    fin_bump;

  lpr_table #(
    .ENTRIES(ROUTE_ENTRIES)
  ) u_table (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_idx_r[IW-1:0]),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  assign expire_in = (cmd_t'(in_command) == CMD_ROUTE) && (in_ttl <= 8'd1);
  assign issue     = rd_idx_r < count_r;
  assign ttl_dead  = ttl_r <= 8'd1;
  assign has_room  = count_r < CW'(ROUTE_ENTRIES);
  assign ifc_ok    = {1'b0, best_ifc_r} < 5'(INTERFACES);

  // compare logic on the entry read last cycle
  assign add_match    = (rd_data.prefix == addr_r) && (rd_data.length == plen_r);
  assign route_match  = (rd_data.length <= 6'(LPR_MAX_LEN)) &&
                        ((addr_r & prefix_mask(rd_data.length)) == rd_data.prefix);
  assign route_better = !best_v_r || (rd_data.length > best_len_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = expire_in ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!issue && !rd_pend_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy   = 1'b1;
    accept = 1'b0;
    rd_en  = 1'b0;
    finish = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy   = 1'b0;
        accept = start;
      end
      ST_SCAN:   rd_en  = issue;
      ST_FINISH: finish = 1'b1;
      default:   busy   = 1'b1;
    endcase
  end

  // decide the result and the table write
  always_comb begin
    fin_status = STAT_NO_ROUTE;
    fin_bump   = 1'b0;
    wr_addr    = count_r[IW-1:0];
    if (cmd_t'(cmd_r) == CMD_ADD) begin
      priority if (hit_r) begin
        fin_status = STAT_ADDED;
        wr_addr    = hit_idx_r;
      end else if (has_room) begin
        fin_status = STAT_ADDED;
        fin_bump   = 1'b1;
      end else begin
        fin_status = STAT_FULL;
      end
    end else begin
      priority if (ttl_dead) begin
        fin_status = STAT_EXPIRED;
      end else if (best_v_r && ifc_ok) begin
        fin_status = STAT_FORWARD;
      end else begin
        fin_status = STAT_NO_ROUTE;
      end
    end
  end

  assign wr_en = finish && (fin_status == STAT_ADDED);

  always_comb begin
    wr_data.prefix      = addr_r;
    wr_data.length      = plen_r;
    wr_data.has_gateway = hasgw_r;
    wr_data.gateway     = hasgw_r ? gw_r : 32'd0;
    wr_data.iface       = ifc_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      rd_pend_r   <= 1'b0;
      hit_r       <= 1'b0;
      best_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_en;
      out_valid_r <= finish;
      if (accept) begin
        rd_idx_r <= '0;
        hit_r    <= 1'b0;
        best_v_r <= 1'b0;
      end else begin
        if (rd_en) begin
          rd_idx_r <= rd_idx_r + CW'(1);
        end
        if (rd_pend_r && add_match) begin
          hit_r <= 1'b1;
        end
        if (rd_pend_r && route_match) begin
          best_v_r <= 1'b1;
        end
      end
      if (finish && fin_bump) begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_command;
      addr_r  <= in_address;
      plen_r  <= in_prefix_length;
      hasgw_r <= in_has_next_hop;
      gw_r    <= in_next_hop;
      ifc_r   <= in_interface_index;
      ttl_r   <= in_ttl;
      proto_r <= in_protocol;
      csum_r  <= in_header_checksum;
    end
    if (rd_en) begin
      cmp_idx_r <= rd_idx_r[IW-1:0];
    end
    // keep the first exact match for an add
    if (rd_pend_r && add_match && !hit_r) begin
      hit_idx_r <= cmp_idx_r;
    end
    // keep the longest match; ties go to the lower slot
    if (rd_pend_r && route_match && route_better) begin
      best_len_r   <= rd_data.length;
      best_ifc_r   <= rd_data.iface;
      best_hasgw_r <= rd_data.has_gateway;
      best_gw_r    <= rd_data.gateway;
    end
    if (finish) begin
      out_status_r <= fin_status;
      if (fin_status == STAT_FORWARD) begin
        out_ifc_r  <= best_ifc_r;
        out_addr_r <= best_hasgw_r ? best_gw_r : addr_r;
        out_ttl_r  <= ttl_r - 8'd1;
        out_csum_r <= csum_update(csum_r, ttl_r, proto_r);
      end else begin
        out_ifc_r  <= '0;
        out_addr_r <= '0;
        out_ttl_r  <= '0;
        out_csum_r <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_interface    = out_ifc_r;
  assign out_fwd_address  = out_addr_r;
  assign out_new_ttl      = out_ttl_r;
  assign out_new_checksum = out_csum_r;

endmodule

@@ test/tb_ipv4_longest_prefix_router.sv @@
// Self-checking testbench for the IPv4 longest-prefix route table block.
module tb_ipv4_longest_prefix_router
  import lpr_pkg::*;
();

  localparam int RANDOM_ITEMS  = 1500;
  localparam int PHASE_ITEMS   = RANDOM_ITEMS / 3;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] addr;
    logic [5:0]  plen;
    logic        has_hop;
    logic [31:0] hop;
    logic [3:0]  ifc;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [15:0] csum;
    int          idle_pct;
    bit          wait_drain;
  } route_req_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  ifc;
    logic [31:0] addr;
    logic [7:0]  ttl;
    logic [15:0] csum;
  } route_outcome_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_command = 1'b0;
  logic [31:0] in_address = '0;
  logic [5:0]  in_prefix_length = '0;
  logic        in_has_next_hop = 1'b0;
  logic [31:0] in_next_hop = '0;
  logic [3:0]  in_interface_index = '0;
  logic [7:0]  in_ttl = '0;
  logic [7:0]  in_protocol = '0;
  logic [15:0] in_header_checksum = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [3:0]  out_interface;
  logic [31:0] out_fwd_address;
  logic [7:0]  out_new_ttl;
  logic [15:0] out_new_checksum;

  route_req_t     pending_reqs[$];
  route_outcome_t route_outcomes_due[$];
  route_req_t     beat_req;
  logic [31:0]    known_pfx[$];
  int             known_len[$];
  entry_t         route_tbl[LPR_ROUTE_ENTRIES];
  bit             route_used[LPR_ROUTE_ENTRIES];
  int             mismatches = 0;
  int             stall_cycles = 0;

  ipv4_longest_prefix_router dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_address         (in_address),
    .in_prefix_length   (in_prefix_length),
    .in_has_next_hop    (in_has_next_hop),
    .in_next_hop        (in_next_hop),
    .in_interface_index (in_interface_index),
    .in_ttl             (in_ttl),
    .in_protocol        (in_protocol),
    .in_header_checksum (in_header_checksum),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_interface      (out_interface),
    .out_fwd_address    (out_fwd_address),
    .out_new_ttl        (out_new_ttl),
    .out_new_checksum   (out_new_checksum)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] prefix_mask(int len);
    if (len <= 0) return 32'h0;
    if (len >= 32) return 32'hFFFF_FFFF;
    return 32'hFFFF_FFFF << (32 - len);
  endfunction

  // Update the shadow route table and work out the beat the block must return.
  function automatic route_outcome_t predict_router_outcome(route_req_t r);
    route_outcome_t res;
    int             slot;
    int             best;
    int             best_len;
    logic [15:0]    old_word;
    logic [15:0]    new_word;
    logic [31:0]    sum;
    res.status = STAT_ADDED;
    res.ifc    = '0;
    res.addr   = '0;
    res.ttl    = '0;
    res.csum   = '0;
    if (r.cmd == CMD_ADD) begin
      slot = -1;
      for (int i = 0; i < LPR_ROUTE_ENTRIES; i++)
        if (slot < 0 && route_used[i] && route_tbl[i].prefix == r.addr &&
            route_tbl[i].length == r.plen)
          slot = i;
      for (int i = 0; i < LPR_ROUTE_ENTRIES; i++)
        if (slot < 0 && !route_used[i]) slot = i;
      if (slot < 0) begin
        res.status = STAT_FULL;
      end else begin
        route_used[slot]            = 1'b1;
        route_tbl[slot].prefix      = r.addr;
        route_tbl[slot].length      = r.plen;
        route_tbl[slot].has_gateway = r.has_hop;
        route_tbl[slot].gateway     = r.has_hop ? r.hop : 32'h0;
        route_tbl[slot].iface       = r.ifc;
      end
    end else if (r.ttl <= 8'd1) begin
      res.status = STAT_EXPIRED;
    end else begin
      best     = -1;
      best_len = 0;
      for (int i = 0; i < LPR_ROUTE_ENTRIES; i++) begin
        if (route_used[i] && int'(route_tbl[i].length) <= LPR_MAX_LEN &&
            (r.addr & prefix_mask(int'(route_tbl[i].length))) == route_tbl[i].prefix &&
            (best < 0 || int'(route_tbl[i].length) > best_len)) begin
          best     = i;
          best_len = int'(route_tbl[i].length);
        end
      end
      if (best < 0 || int'(route_tbl[best].iface) >= LPR_INTERFACES) begin
        res.status = STAT_NO_ROUTE;
      end else begin
        // ones' complement incremental update of the TTL/protocol word
        old_word   = {r.ttl, r.proto};
        new_word   = {r.ttl - 8'd1, r.proto};
        sum        = {16'h0, ~r.csum} + {16'h0, ~old_word} + {16'h0, new_word};
        sum        = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
        sum        = {16'h0, sum[15:0]} + {16'h0, sum[31:16]};
        res.status = STAT_FORWARD;
        res.ifc    = route_tbl[best].iface;
        res.addr   = route_tbl[best].has_gateway ? route_tbl[best].gateway : r.addr;
        res.ttl    = r.ttl - 8'd1;
        res.csum   = ~sum[15:0];
      end
    end
    return res;
  endfunction

  function automatic route_req_t make_req(cmd_t cmd, logic [31:0] addr, logic [5:0] plen,
                                          logic has_hop, logic [31:0] hop, logic [3:0] ifc,
                                          logic [7:0] ttl, logic [7:0] proto,
                                          logic [15:0] csum);
    route_req_t r;
    r.cmd        = cmd;
    r.addr       = addr;
    r.plen       = plen;
    r.has_hop    = has_hop;
    r.hop        = hop;
    r.ifc        = ifc;
    r.ttl        = ttl;
    r.proto      = proto;
    r.csum       = csum;
    r.idle_pct   = 8;
    r.wait_drain = 1'b0;
    return r;
  endfunction

  task automatic queue_req(route_req_t r);
    pending_reqs.push_back(r);
    if (r.cmd == CMD_ADD) begin
      known_pfx.push_back(r.addr);
      known_len.push_back(int'(r.plen));
    end
  endtask

  // Mostly adds that nest under known routes and datagrams aimed at them,
  // with some fully random noise.
  function automatic route_req_t random_req(int idle_pct);
    route_req_t  r;
    int          pick;
    int          sel;
    int          k;
    int          base;
    int          len;
    logic [31:0] m;
    r = make_req(cmd_t'($urandom_range(1, 0)), $urandom, 6'($urandom), 1'($urandom),
                 $urandom, 4'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
    r.idle_pct = idle_pct;
    pick = int'($urandom_range(99, 0));
    k    = int'($urandom_range(known_pfx.size() - 1, 0));
    m    = prefix_mask(known_len[k]);
    if (pick < 22) begin
      r.cmd = CMD_ADD;
      sel   = int'($urandom_range(99, 0));
      if (sel < 30) begin
        r.addr = known_pfx[k];
        r.plen = 6'(known_len[k]);
      end else if (sel < 70) begin
        base   = (known_len[k] >= 32) ? 32 : known_len[k] + 1;
        len    = int'($urandom_range(32, base));
        r.addr = (known_pfx[k] & m) | ($urandom & ~m & prefix_mask(len));
        r.plen = 6'(len);
      end else if (sel < 85) begin
        len    = int'($urandom_range(32, 0));
        r.addr = $urandom & prefix_mask(len);
        r.plen = 6'(len);
      end else if (sel < 93) begin
        r.plen = 6'($urandom_range(63, 33));
      end else begin
        // set a host bit so the route can never match
        r.plen = 6'($urandom_range(31, 1));
        r.addr = $urandom | 32'h1;
      end
    end else if (pick < 90) begin
      r.cmd  = CMD_ROUTE;
      r.addr = (known_pfx[k] & m) | ($urandom & ~m);
      if ($urandom_range(9, 0) == 0) r.ttl = 8'($urandom_range(1, 0));
      else r.ttl = 8'($urandom_range(255, 2));
    end
    return r;
  endfunction

  // Driver: one beat per accept, new item offered in the same cycle when allowed.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) route_outcomes_due.push_back(predict_router_outcome(beat_req));
      if (!start || !busy) begin
        if (pending_reqs.size() > 0 &&
            !(pending_reqs[0].wait_drain &&
              (busy || out_valid || route_outcomes_due.size() != 0)) &&
            $urandom_range(99, 0) >= pending_reqs[0].idle_pct) begin
          beat_req = pending_reqs.pop_front();
          in_command         <= beat_req.cmd;
          in_address         <= beat_req.addr;
          in_prefix_length   <= beat_req.plen;
          in_has_next_hop    <= beat_req.has_hop;
          in_next_hop        <= beat_req.hop;
          in_interface_index <= beat_req.ifc;
          in_ttl             <= beat_req.ttl;
          in_protocol        <= beat_req.proto;
          in_header_checksum <= beat_req.csum;
          start              <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic report_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // Monitor and watchdog.
  always @(posedge clk) begin
    route_outcome_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (route_outcomes_due.size() == 0) begin
          $display("%0t: unexpected result beat, expected none actual status %0d",
                   $time, out_status);
          mismatches++;
        end else begin
          want = route_outcomes_due.pop_front();
          report_field("status", 32'(want.status), 32'(out_status));
          report_field("interface", 32'(want.ifc), 32'(out_interface));
          report_field("address", want.addr, out_fwd_address);
          report_field("new_ttl", 32'(want.ttl), 32'(out_new_ttl));
          report_field("new_checksum", 32'(want.csum), 32'(out_new_checksum));
        end
      end
      if ((start && !busy) || out_valid) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    route_req_t r;
    for (int i = 0; i < LPR_ROUTE_ENTRIES; i++) route_used[i] = 1'b0;

    // empty table, then expiry ahead of lookup
    queue_req(make_req(CMD_ROUTE, 32'h0A01_0203, 6'd0, 1'b0, 32'h0, 4'd0, 8'd64, 8'd6,
                       16'h1234));
    queue_req(make_req(CMD_ROUTE, 32'h0A01_0203, 6'd0, 1'b0, 32'h0, 4'd0, 8'd0, 8'd6,
                       16'h1234));
    queue_req(make_req(CMD_ROUTE, 32'h0A01_0203, 6'd0, 1'b0, 32'h0, 4'd0, 8'd1, 8'd17,
                       16'hFFFF));
    // default, nested, host-bit and over-long routes
    queue_req(make_req(CMD_ADD, 32'h0, 6'd0, 1'b1, 32'hC0A8_0001, 4'd15, 8'd0, 8'd0, 16'h0));
    queue_req(make_req(CMD_ADD, 32'h0A00_0000, 6'd8, 1'b0, 32'hDEAD_BEEF, 4'd1, 8'd0, 8'd0,
                       16'h0));
    queue_req(make_req(CMD_ADD, 32'h0A01_0000, 6'd16, 1'b1, 32'h0A00_00FE, 4'd2, 8'd0, 8'd0,
                       16'h0));
    queue_req(make_req(CMD_ADD, 32'h0A01_0203, 6'd32, 1'b1, 32'hFFFF_FFFF, 4'd0, 8'd0, 8'd0,
                       16'h0));
    queue_req(make_req(CMD_ADD, 32'hC0A8_0101, 6'd24, 1'b1, 32'h1111_1111, 4'd3, 8'd0, 8'd0,
                       16'h0));
    queue_req(make_req(CMD_ADD, 32'hC0A8_0100, 6'd40, 1'b1, 32'h2222_2222, 4'd5, 8'd0, 8'd0,
                       16'h0));
    queue_req(make_req(CMD_ADD, 32'hFFFF_FFFF, 6'd63, 1'b1, 32'h3333_3333, 4'd6, 8'd0, 8'd0,
                       16'h0));
    queue_req(make_req(CMD_ADD, 32'hFFFF_FFFF, 6'd32, 1'b0, 32'h4444_4444, 4'd7, 8'd0, 8'd0,
                       16'h0));
    queue_req(make_req(CMD_ROUTE, 32'h0A01_0203, 6'd0, 1'b0, 32'h0, 4'd0, 8'd255, 8'hFF,
                       16'h0000));
    queue_req(make_req(CMD_ROUTE, 32'h0A01_0204, 6'd0, 1'b0, 32'h0, 4'd0, 8'd2, 8'h00,
                       16'hFFFF));
    queue_req(make_req(CMD_ROUTE, 32'h0A02_0000, 6'd0, 1'b0, 32'h0, 4'd0, 8'd64, 8'd17,
                       16'hB1E6));
    // overwrite the /8 route in place
    queue_req(make_req(CMD_ADD, 32'h0A00_0000, 6'd8, 1'b1, 32'h0A00_00FD, 4'd4, 8'd0, 8'd0,
                       16'h0));
    queue_req(make_req(CMD_ROUTE, 32'h0A02_0000, 6'd0, 1'b0, 32'h0, 4'd0, 8'd128, 8'd1,
                       16'h8000));
    queue_req(make_req(CMD_ROUTE, 32'hC0A8_0101, 6'd0, 1'b0, 32'h0, 4'd0, 8'd30, 8'd6,
                       16'h5A5A));
    queue_req(make_req(CMD_ROUTE, 32'hC0A8_0100, 6'd0, 1'b0, 32'h0, 4'd0, 8'd30, 8'd6,
                       16'hA5A5));
    queue_req(make_req(CMD_ROUTE, 32'hFFFF_FFFF, 6'd0, 1'b0, 32'h0, 4'd0, 8'd3, 8'd50,
                       16'h0001));
    queue_req(make_req(CMD_ROUTE, 32'h0000_0000, 6'd0, 1'b0, 32'h0, 4'd0, 8'd1, 8'd6,
                       16'h7FFF));
    queue_req(make_req(CMD_ROUTE, 32'h0000_0000, 6'd0, 1'b0, 32'h0, 4'd0, 8'd10, 8'd6,
                       16'hFFFE));

    // each phase opens after the table has gone quiet
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = random_req(n < PHASE_ITEMS ? 8 : (n < 2 * PHASE_ITEMS ? 65 : 0));
      r.wait_drain = (n % PHASE_ITEMS == 0);
      queue_req(r);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_reqs.size() != 0 || start || route_outcomes_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/lpr_pkg.sv
rtl/core/lpr_table.sv
rtl/core/ipv4_longest_prefix_router.sv
test/tb_ipv4_longest_prefix_router.sv
